### hw/rtl/cpmq_pkg.sv
`timescale 1ns / 1ps
package cpmq_pkg;

  // Default number of queue entries.
  localparam int unsigned CPMQ_DEPTH = 8;

  // Widths of one stored entry and of the reported entry count.
  localparam int unsigned HDR_W = 40;
  localparam int unsigned PAY_W = 48;
  localparam int unsigned CNT_W = 4;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_POP,
    S_FINISH
  } state_t;

  // One request item.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  priority_req;
    logic [7:0]  action_char;
    logic [7:0]  first_command;
    logic [7:0]  first_key;
    logic [15:0] first_value;
    logic [7:0]  second_command;
    logic [7:0]  second_key;
    logic [15:0] second_value;
    logic [7:0]  delimiter_char;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [7:0]       out_priority;
    logic [7:0]       out_action;
    logic [7:0]       out_first_command;
    logic [7:0]       out_first_key;
    logic [15:0]      out_first_value;
    logic [7:0]       out_second_command;
    logic [7:0]       out_second_key;
    logic [15:0]      out_second_value;
    logic [7:0]       out_delimiter;
    logic [CNT_W-1:0] entry_count;
    logic             queue_was_empty;
    logic             dropped_oldest;
  } res_t;

endpackage

### hw/rtl/cpmq_req_if.sv
`timescale 1ns / 1ps
interface cpmq_req_if;
  logic              valid;
  logic              ready;
  cpmq_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/cpmq_res_if.sv
`timescale 1ns / 1ps
interface cpmq_res_if;
  logic              valid;
  logic              ready;
  cpmq_pkg::res_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/coalescing_priority_message_queue_unit.sv
`timescale 1ns / 1ps
// Coalescing message queue.
// The request channel carries one operation per transaction: insert with
// coalescing, plain append, or pop of the oldest entry. The result channel
// returns exactly one transaction per request, in request order.
// Entries live in two RAMs (header and payload), each with one write port and
// one registered read port, organized as a ring addressed from a head pointer,
// so a pop or a drop never moves data. Requests are taken one at a time.
// Append, ignored codes, a pop of an empty queue and an insert into an empty
// queue go from the decide state straight to finish; a pop of a held entry
// passes through the pop state. An insert into a nonempty queue scans the
// held entries through the registered read port, one per cycle, from the
// oldest, and finishes at the first match or after the newest entry; the scan
// sets the rate. The controller then returns to idle, where the next request
// is accepted, which may happen while the last result waits.
// When the receiver stalls, a finished result waits in the controller until
// the output register frees up, and no new request is taken.
// Reset clears the occupancy, the head pointer and the output valid and holds
// ready low; RAM contents are left as they are and unwritten ones are never used.
module coalescing_priority_message_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = cpmq_pkg::CPMQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  cpmq_req_if.sink   request,
  cpmq_res_if.source result
);
  import cpmq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Ring position of a logical offset from the head.
  function automatic logic [AW-1:0] wrap_addr(logic [AW-1:0] base, logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  state_t        state, state_next;
  req_t          req, req_next;
  res_t          res, res_next;
  res_t          out_data;
  logic          out_valid;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;
  logic [AW-1:0] cmp_addr, cmp_addr_next;
  logic          rd_pend, rd_pend_next;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [HDR_W-1:0] hdr_wdata, hdr_rdata;
  logic [PAY_W-1:0] pay_wdata, pay_rdata;

  logic [HDR_W-1:0] new_hdr;
  logic [PAY_W-1:0] new_pay;
  logic [AW-1:0]    tail_addr, head_inc;
  logic             full, scan_hit, scan_last, do_append;

  // Storage.
  cpmq_ram #(.WIDTH(HDR_W), .DEPTH(QUEUE_DEPTH)) u_hdr_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(hdr_wdata),
    .raddr(raddr), .rdata(hdr_rdata)
  );

  cpmq_ram #(.WIDTH(PAY_W), .DEPTH(QUEUE_DEPTH)) u_pay_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pay_wdata),
    .raddr(raddr), .rdata(pay_rdata)
  );

  // Entry packing of the held request.
  assign new_hdr = {req.delimiter_char, req.second_command, req.first_command,
                    req.action_char, req.priority_req};
  assign new_pay = {req.second_value, req.second_key, req.first_value, req.first_key};
  assign hdr_wdata = new_hdr;
  assign pay_wdata = new_pay;

  assign full      = (occ == DEPTH_C);
  assign tail_addr = wrap_addr(head, occ);
  assign head_inc  = wrap_addr(head, CW'(1));

  // Coalescing match on the entry read in the previous cycle.
  assign scan_hit  = rd_pend &&
                     ((req.priority_req < hdr_rdata[7:0]) ||
                      ((req.priority_req == hdr_rdata[7:0]) &&
                       (hdr_rdata[31:16] == {req.second_command, req.first_command})));
  assign scan_last = rd_pend && (cmp_idx == (occ - CW'(1)));

  assign request.ready = (state == S_IDLE) && !rst;
  assign result.valid  = out_valid;
  assign result.data   = out_data;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (request.valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority case (req.cmd)
          OP_INSERT: state_next = (occ == '0) ? S_FINISH : S_SCAN;
          OP_POP:    state_next = (occ == '0) ? S_FINISH : S_POP;
          default:   state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_POP: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control: RAM accesses, pointer updates and result building.
  always_comb begin
    req_next      = req;
    res_next      = res;
    head_next     = head;
    occ_next      = occ;
    scan_idx_next = scan_idx;
    cmp_idx_next  = cmp_idx;
    cmp_addr_next = cmp_addr;
    rd_pend_next  = 1'b0;
    we            = 1'b0;
    waddr         = tail_addr;
    raddr         = head;
    do_append     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (request.valid) begin
          req_next = request.data;
        end
        scan_idx_next = '0;
      end
      S_DECIDE: begin
        res_next = '0;
        priority case (req.cmd)
          OP_INSERT: do_append = (occ == '0);
          OP_APPEND: do_append = 1'b1;
          OP_POP:    res_next.queue_was_empty = (occ == '0);
          default:   res_next.queue_was_empty = 1'b0;
        endcase
      end
      S_SCAN: begin
        raddr         = wrap_addr(head, scan_idx);
        cmp_idx_next  = scan_idx;
        cmp_addr_next = raddr;
        if (scan_idx < occ) begin
          scan_idx_next = scan_idx + CW'(1);
          rd_pend_next  = 1'b1;
        end
        if (scan_hit) begin
          we    = 1'b1;
          waddr = cmp_addr;
        end else if (scan_last) begin
          do_append = 1'b1;
        end
      end
      S_POP: begin
        res_next.out_priority       = hdr_rdata[7:0];
        res_next.out_action         = hdr_rdata[15:8];
        res_next.out_first_command  = hdr_rdata[23:16];
        res_next.out_second_command = hdr_rdata[31:24];
        res_next.out_delimiter      = hdr_rdata[39:32];
        res_next.out_first_key      = pay_rdata[7:0];
        res_next.out_first_value    = pay_rdata[23:8];
        res_next.out_second_key     = pay_rdata[31:24];
        res_next.out_second_value   = pay_rdata[47:32];
        head_next = head_inc;
        occ_next  = occ - CW'(1);
      end
      S_FINISH: begin
        res_next = res;
      end
      default: res_next = res;
    endcase

    // Tail write; a full ring overwrites the oldest slot and moves the head.
    if (do_append) begin
      we    = 1'b1;
      waddr = tail_addr;
      if (full) begin
        head_next               = head_inc;
        res_next.dropped_oldest = 1'b1;
      end else begin
        occ_next = occ + CW'(1);
      end
    end

    if (state == S_DECIDE || state == S_SCAN || state == S_POP) begin
      res_next.entry_count = CNT_W'(occ_next);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      occ     <= occ_next;
      rd_pend <= rd_pend_next;
      if (state == S_FINISH && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req      <= req_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    cmp_addr <= cmp_addr_next;
    if (state == S_FINISH && (!out_valid || result.ready)) begin
      out_data <= res;
    end
  end

  // Checks.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_C)
    else $error("occupancy exceeds queue depth");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result presented without a finished operation");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_DECIDE || state == S_SCAN))
    else $error("RAM write outside a modifying state");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.queue_was_empty) |->
      (out_data.out_priority == '0 && out_data.entry_count == '0 &&
       !out_data.dropped_oldest))
    else $error("empty pop result carries data");

  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_pend) |-> $past(state == S_SCAN))
    else $error("scan compare without an issued read");

endmodule

### hw/rtl/cpmq_ram.sv
`timescale 1ns / 1ps
module cpmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
